// ----- sv/cds_pkg.sv -----
// Shared types and constants for the codel size detector.
// Used by the controller, the datapath and the top level; depends on nothing.
package cds_pkg;

    // Field and register widths
    localparam int DIM_W     = 13;
    localparam int RUN_W     = DIM_W + 1;
    localparam int PIXEL_W   = 8;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 2;
    localparam int DIM_MAX   = (2 ** DIM_W) - 1;

    // Default parameter values
    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;
    localparam int DEF_COLOR_BITS = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIXED_SIZE   = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_WIDTH  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_HEIGHT = 2'd2;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_SIZE,
        ST_DIV_W,
        ST_DIV_H,
        ST_OUTPUT
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic accept;
        logic update;
        logic div_load_w;
        logic div_load_h;
        logic div_step;
        logic load_out;
    } ctrl_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic frame_end;
        logic div_done;
        logic out_free;
    } dp_status_t;

endpackage

// ----- sv/cds_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
module cds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- sv/cds_ctrl.sv -----
// Controller state machine for the codel size detector.
// Depends on cds_pkg for the state type and the command and status structs.
module cds_ctrl import cds_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  dp_status_t sts,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                state_next = sts.frame_end ? ST_SIZE : ST_IDLE;
            end
            ST_SIZE: begin
                state_next = ST_DIV_W;
            end
            ST_DIV_W: begin
                if (sts.div_done) begin
                    state_next = ST_DIV_H;
                end
            end
            ST_DIV_H: begin
                if (sts.div_done) begin
                    state_next = ST_OUTPUT;
                end
            end
            ST_OUTPUT: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
            end
            ST_SIZE: begin
                cmd.div_load_w = 1'b1;
            end
            ST_DIV_W: begin
                cmd.div_load_h = sts.div_done;
                cmd.div_step   = !sts.div_done;
            end
            ST_DIV_H: begin
                cmd.div_step = !sts.div_done;
            end
            ST_OUTPUT: begin
                cmd.load_out = sts.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ----- sv/cds_datapath.sv -----
// Datapath: configuration registers, run tracking, column store, divider and
// result register. Depends on cds_pkg and instantiates cds_ram.
module cds_datapath import cds_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int COLOR_BITS = DEF_COLOR_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    input  logic [PIXEL_W-1:0]   s_pixel_color,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [DIM_W-1:0]     m_codel_size,
    output logic [DIM_W-1:0]     m_reduced_width,
    output logic [DIM_W-1:0]     m_reduced_height,
    output logic [STATUS_W-1:0]  m_status,
    input  ctrl_cmd_t            cmd,
    output dp_status_t           sts
);

    localparam int W_CAP_I = (MAX_WIDTH < DIM_MAX) ? MAX_WIDTH : DIM_MAX;
    localparam int H_CAP_I = (MAX_HEIGHT < DIM_MAX) ? MAX_HEIGHT : DIM_MAX;
    localparam int CB      = (COLOR_BITS < PIXEL_W) ? COLOR_BITS : PIXEL_W;
    localparam int AW      = (W_CAP_I > 1) ? $clog2(W_CAP_I) : 1;
    localparam int RAM_W   = CB + DIM_W;
    localparam int CNT_W   = $clog2(DIM_W + 1);

    localparam logic [DIM_W-1:0] W_CAP     = DIM_W'(W_CAP_I);
    localparam logic [DIM_W-1:0] H_CAP     = DIM_W'(H_CAP_I);
    localparam logic [DIM_W-1:0] DIM_ONE   = DIM_W'(1);
    localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(DIM_W);

    // Configuration registers
    logic [DIM_W-1:0] cfg_width_reg;
    logic [DIM_W-1:0] cfg_height_reg;
    logic [DIM_W-1:0] cfg_fixed_reg;

    // Frame position and row run state
    logic [DIM_W-1:0] col_pos_reg;
    logic [DIM_W-1:0] row_pos_reg;
    logic [CB-1:0]    color_reg;
    logic [CB-1:0]    row_last_reg;
    logic [DIM_W-1:0] row_start_reg;
    logic [RUN_W-1:0] shortest_reg;

    // Divider
    logic [DIM_W-1:0] div_size_reg;
    logic [DIM_W-1:0] div_rem_reg;
    logic [DIM_W-1:0] div_quo_reg;
    logic [CNT_W-1:0] div_cnt_reg;
    logic [DIM_W-1:0] w_quo_reg;
    logic             w_inexact_reg;

    // Result register
    logic                out_valid_reg;
    logic [DIM_W-1:0]    out_size_reg;
    logic [DIM_W-1:0]    out_rw_reg;
    logic [DIM_W-1:0]    out_rh_reg;
    logic [STATUS_W-1:0] out_status_reg;

    // Combinational signals
    logic [DIM_W-1:0]    w_dim;
    logic [DIM_W-1:0]    h_dim;
    logic                restart;
    logic [DIM_W-1:0]    x_eff;
    logic [DIM_W-1:0]    y_eff;
    logic [RAM_W-1:0]    ram_rdata;
    logic [RAM_W-1:0]    ram_wdata;
    logic [CB-1:0]       col_last;
    logic [DIM_W-1:0]    col_start;
    logic                row_first;
    logic                row_change;
    logic                row_end;
    logic [DIM_W-1:0]    row_start_new;
    logic [DIM_W-1:0]    row_run_mid;
    logic [DIM_W-1:0]    row_run_end;
    logic                col_first;
    logic                col_change;
    logic                col_end;
    logic [DIM_W-1:0]    col_start_new;
    logic [DIM_W-1:0]    col_run_mid;
    logic [DIM_W-1:0]    col_run_end;
    logic [RUN_W-1:0]    best;
    logic [DIM_W-1:0]    size_sel;
    logic [RUN_W-1:0]    div_shift;
    logic [RUN_W-1:0]    div_trial;
    logic                div_fits;
    logic [STATUS_W-1:0] status_new;

    // Clamp the configured dimensions
    always_comb begin
        if (cfg_width_reg == '0) begin
            w_dim = DIM_ONE;
        end else if (cfg_width_reg > W_CAP) begin
            w_dim = W_CAP;
        end else begin
            w_dim = cfg_width_reg;
        end
        if (cfg_height_reg == '0) begin
            h_dim = DIM_ONE;
        end else if (cfg_height_reg > H_CAP) begin
            h_dim = H_CAP;
        end else begin
            h_dim = cfg_height_reg;
        end
    end

    // Restart the frame when the position falls outside the dimensions
    assign restart = (col_pos_reg >= w_dim) || (row_pos_reg >= h_dim);
    assign x_eff   = restart ? '0 : col_pos_reg;
    assign y_eff   = restart ? '0 : row_pos_reg;

    // Column store: last color and run start of each column
    cds_ram #(
        .WIDTH (RAM_W),
        .DEPTH (W_CAP_I)
    ) u_col_ram (
        .clk   (aclk),
        .we    (cmd.update),
        .waddr (col_pos_reg[AW-1:0]),
        .wdata (ram_wdata),
        .re    (cmd.accept),
        .raddr (x_eff[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign col_last  = ram_rdata[RAM_W-1 -: CB];
    assign col_start = ram_rdata[DIM_W-1:0];
    assign ram_wdata = {color_reg, col_start_new};

    // Row runs
    always_comb begin
        row_first     = (col_pos_reg == '0);
        row_change    = !row_first && (row_last_reg != color_reg);
        row_start_new = row_first ? '0 : (row_change ? col_pos_reg : row_start_reg);
        row_run_mid   = col_pos_reg - row_start_reg;
        row_end       = (col_pos_reg == w_dim - DIM_ONE);
        row_run_end   = w_dim - row_start_new;
    end

    // Column runs
    always_comb begin
        col_first     = (row_pos_reg == '0);
        col_change    = !col_first && (col_last != color_reg);
        col_start_new = col_first ? '0 : (col_change ? row_pos_reg : col_start);
        col_run_mid   = row_pos_reg - col_start;
        col_end       = (row_pos_reg == h_dim - DIM_ONE);
        col_run_end   = h_dim - col_start_new;
    end

    // Keep the shortest closed run
    always_comb begin
        if (row_first && col_first) begin
            best = {1'b0, w_dim} + RUN_W'(1);
        end else begin
            best = shortest_reg;
        end
        if (row_change && ({1'b0, row_run_mid} < best)) begin
            best = {1'b0, row_run_mid};
        end
        if (row_end && ({1'b0, row_run_end} < best)) begin
            best = {1'b0, row_run_end};
        end
        if (col_change && ({1'b0, col_run_mid} < best)) begin
            best = {1'b0, col_run_mid};
        end
        if (col_end && ({1'b0, col_run_end} < best)) begin
            best = {1'b0, col_run_end};
        end
    end

    // Pick the codel size
    always_comb begin
        size_sel = (cfg_fixed_reg != '0) ? cfg_fixed_reg : shortest_reg[DIM_W-1:0];
        if (size_sel == '0) begin
            size_sel = DIM_ONE;
        end
    end

    // One restoring division step
    assign div_shift = {div_rem_reg, div_quo_reg[DIM_W-1]};
    assign div_fits  = (div_shift >= {1'b0, div_size_reg});
    assign div_trial = div_shift - {1'b0, div_size_reg};

    // Result status
    always_comb begin
        if (w_inexact_reg) begin
            status_new = STATUS_BAD_WIDTH;
        end else if (div_rem_reg != '0) begin
            status_new = STATUS_BAD_HEIGHT;
        end else begin
            status_new = STATUS_OK;
        end
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_width_reg  <= DIM_ONE;
            cfg_height_reg <= DIM_ONE;
            cfg_fixed_reg  <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:  cfg_width_reg  <= cfg_data;
                CFG_FRAME_HEIGHT: cfg_height_reg <= cfg_data;
                CFG_FIXED_SIZE:   cfg_fixed_reg  <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Pixel capture, run tracking and position advance
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_pos_reg   <= '0;
            row_pos_reg   <= '0;
            row_last_reg  <= '0;
            row_start_reg <= '0;
            shortest_reg  <= RUN_W'(2);
        end else if (cmd.accept) begin
            col_pos_reg <= x_eff;
            row_pos_reg <= y_eff;
        end else if (cmd.update) begin
            row_last_reg  <= color_reg;
            row_start_reg <= row_start_new;
            shortest_reg  <= best;
            if (row_end) begin
                col_pos_reg <= '0;
                row_pos_reg <= col_end ? '0 : row_pos_reg + DIM_ONE;
            end else begin
                col_pos_reg <= col_pos_reg + DIM_ONE;
            end
        end
    end

    // Hold the color of the pixel in work
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            color_reg <= s_pixel_color[CB-1:0];
        end
    end

    // Divider: width first, then height
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_cnt_reg <= '0;
        end else if (cmd.div_load_w || cmd.div_load_h) begin
            div_cnt_reg <= '0;
        end else if (cmd.div_step) begin
            div_cnt_reg <= div_cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_load_w) begin
            div_size_reg <= size_sel;
            div_rem_reg  <= '0;
            div_quo_reg  <= w_dim;
        end else if (cmd.div_load_h) begin
            w_quo_reg     <= div_quo_reg;
            w_inexact_reg <= (div_rem_reg != '0);
            div_rem_reg   <= '0;
            div_quo_reg   <= h_dim;
        end else if (cmd.div_step) begin
            div_rem_reg <= div_fits ? div_trial[DIM_W-1:0] : div_shift[DIM_W-1:0];
            div_quo_reg <= {div_quo_reg[DIM_W-2:0], div_fits};
        end
    end

    // Result register: drop on handshake, load when free
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_size_reg   <= div_size_reg;
            out_status_reg <= status_new;
            out_rw_reg     <= (status_new == STATUS_OK) ? w_quo_reg : '0;
            out_rh_reg     <= (status_new == STATUS_OK) ? div_quo_reg : '0;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_codel_size     = out_size_reg;
    assign m_reduced_width  = out_rw_reg;
    assign m_reduced_height = out_rh_reg;
    assign m_status         = out_status_reg;

    // Status to the controller
    assign sts.frame_end = row_end && col_end;
    assign sts.div_done  = (div_cnt_reg == DIV_STEPS);
    assign sts.out_free  = !out_valid_reg || m_ready;

endmodule

// ----- sv/codel_size_detector.sv -----
// Top level of the codel size detector: controller plus datapath.
// Depends on cds_pkg, cds_ctrl and cds_datapath.
//
//  channel   direction  handshake           payload
//  s_        in         s_valid / s_ready   s_pixel_color
//  m_        out        m_valid / m_ready   m_codel_size, m_reduced_width,
//                                           m_reduced_height, m_status
//  cfg_      in         cfg_wr_en           cfg_index, cfg_data
//
// Pixels are not taken back to back: the column store read is registered, so the
// run update comes in the cycle after the accept and the input waits for it.
// The last pixel of a frame is followed by two 13-step divisions on one
// shared restoring divider, plus loading the divider and the result register.
// Reset is synchronous; the column store is not cleared.
// A result waits in the output register while pixels of the next frame go on;
// the next frame end stalls the input until that result is taken.
module codel_size_detector import cds_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int COLOR_BITS = DEF_COLOR_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [PIXEL_W-1:0]   s_pixel_color,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [DIM_W-1:0]     m_codel_size,
    output logic [DIM_W-1:0]     m_reduced_width,
    output logic [DIM_W-1:0]     m_reduced_height,
    output logic [STATUS_W-1:0]  m_status
);

    ctrl_cmd_t  cmd;
    dp_status_t sts;

    // Sequencing
    cds_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Run tracking, division and result
    cds_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .COLOR_BITS (COLOR_BITS)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_pixel_color    (s_pixel_color),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_codel_size     (m_codel_size),
        .m_reduced_width  (m_reduced_width),
        .m_reduced_height (m_reduced_height),
        .m_status         (m_status),
        .cmd              (cmd),
        .sts              (sts)
    );

`ifndef NO_ASSERTIONS
    // A transaction on the input is always followed by its update cycle
    a_accept_then_update: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (cmd.update && !s_ready))
        else $error("input accepted without a following update cycle");

    // A failed size never reports reduced dimensions
    a_error_zero_dims: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != STATUS_OK)) |->
            ((m_reduced_width == '0) && (m_reduced_height == '0)))
        else $error("reduced dimensions nonzero on error status");

    // The divider never steps past its last quotient bit
    a_div_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> !sts.div_done)
        else $error("divider stepped after completion");

    // A result is never loaded over one still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_valid || m_ready))
        else $error("result register overwritten");
`endif

endmodule
